// File: rtl/dmms_pkg.sv
package dmms_pkg;

	// Default widths
	localparam int SECONDS_WIDTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF   = 32;

	// Microsecond field
	localparam int          USEC_W       = 20;
	localparam int          USEC_IDX_W   = $clog2(USEC_W);
	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
	localparam logic [19:0] USEC_MAX     = 20'd999999;

	// Mean sequencer states
	typedef enum logic [2:0] {
		MS_IDLE,
		MS_LOAD,
		MS_DIVS,
		MS_MUL,
		MS_ADDU,
		MS_DIVU,
		MS_DONE
	} mean_state_t;

endpackage

// File: rtl/duration_min_max_mean_stats_top.sv
// A request is taken only while the mean sequencer is idle, so the next
//   one waits until its shared add/subtract unit has finished the previous
//   mean (divide, x1e6, divide) and handed it to the result register.
// The result register lets the next request in while a result waits.
// Reset (arst_n, async): count, min, max and totals clear; min/max read unset.
module duration_min_max_mean_stats_top #(
	parameter int SECONDS_WIDTH = dmms_pkg::SECONDS_WIDTH_DEF,
	parameter int COUNT_WIDTH   = dmms_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [SECONDS_WIDTH-1:0]    sample_sec,
	input  logic [dmms_pkg::USEC_W-1:0] sample_usec,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [COUNT_WIDTH-1:0]      use_count,
	output logic [SECONDS_WIDTH-1:0]    min_sec,
	output logic [dmms_pkg::USEC_W-1:0] min_usec,
	output logic [SECONDS_WIDTH-1:0]    max_sec,
	output logic [dmms_pkg::USEC_W-1:0] max_usec,
	output logic [SECONDS_WIDTH-1:0]    mean_sec,
	output logic [dmms_pkg::USEC_W-1:0] mean_usec
);

	localparam int UW   = dmms_pkg::USEC_W;
	localparam int SW   = SECONDS_WIDTH;
	localparam int SUMW = SECONDS_WIDTH + COUNT_WIDTH;

	function automatic logic dur_less(input logic [SW-1:0] as, input logic [UW-1:0] au,
		input logic [SW-1:0] bs, input logic [UW-1:0] bu);
		return (as < bs) || (as == bs && au < bu);
	endfunction

	logic [COUNT_WIDTH-1:0] count_q;
	logic [SW-1:0]          least_sec_q, most_sec_q;
	logic [UW-1:0]          least_usec_q, most_usec_q;
	logic [SUMW-1:0]        sum_sec_q;
	logic [UW-1:0]          sum_usec_q;
	logic                   out_valid_q;

	logic          accept;
	logic [UW-1:0] u;
	logic [UW:0]   nu_raw;
	logic          carry;
	logic [UW-1:0] nu;
	logic [SW:0]   ns;
	logic [SUMW:0] sum_ext;

	logic          mean_idle, mean_done, take;
	logic [SW-1:0] mean_sec_w;
	logic [UW-1:0] mean_usec_w;

	assign accept   = in_valid && in_ready;
	assign in_ready = mean_idle;
	assign take     = !out_valid_q || out_ready;

	// Clamp sample, total with one carry into seconds
	assign u       = (sample_usec > dmms_pkg::USEC_MAX) ? dmms_pkg::USEC_MAX : sample_usec;
	assign nu_raw  = {1'b0, sum_usec_q} + {1'b0, u};
	assign carry   = (nu_raw >= {1'b0, dmms_pkg::USEC_PER_SEC});
	assign nu      = carry ? UW'(nu_raw - {1'b0, dmms_pkg::USEC_PER_SEC}) : nu_raw[UW-1:0];
	assign ns      = {1'b0, sample_sec} + (SW + 1)'(carry);
	assign sum_ext = {1'b0, sum_sec_q} + (SUMW + 1)'(ns);

	// Statistics update on request accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			least_sec_q  <= '0;
			least_usec_q <= '0;
			most_sec_q   <= '0;
			most_usec_q  <= '0;
			sum_sec_q    <= '0;
			sum_usec_q   <= '0;
		end else if (accept) begin
			if (count_q != '1) count_q <= count_q + 1'b1;
			if ((least_sec_q == '0 && least_usec_q == '0) ||
				dur_less(sample_sec, u, least_sec_q, least_usec_q)) begin
				least_sec_q  <= sample_sec;
				least_usec_q <= u;
			end
			if ((most_sec_q == '0 && most_usec_q == '0) ||
				dur_less(most_sec_q, most_usec_q, sample_sec, u)) begin
				most_sec_q  <= sample_sec;
				most_usec_q <= u;
			end
			if (sum_ext[SUMW]) begin
				sum_sec_q  <= '1;
				sum_usec_q <= dmms_pkg::USEC_MAX;
			end else begin
				sum_sec_q  <= sum_ext[SUMW-1:0];
				sum_usec_q <= nu;
			end
		end
	end

	dmms_mean #(
		.SECONDS_WIDTH(SECONDS_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_mean (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.take     (take),
		.count    (count_q),
		.sum_sec  (sum_sec_q),
		.sum_usec (sum_usec_q),
		.idle     (mean_idle),
		.done     (mean_done),
		.mean_sec (mean_sec_w),
		.mean_usec(mean_usec_w)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (mean_done && take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (mean_done && take) begin
			use_count <= count_q;
			min_sec   <= least_sec_q;
			min_usec  <= least_usec_q;
			max_sec   <= most_sec_q;
			max_usec  <= most_usec_q;
			mean_sec  <= mean_sec_w;
			mean_usec <= mean_usec_w;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/dmms_mean.sv
// Mean sequencer: total / count through one shared add/subtract unit.
// Seconds: restoring division of the total seconds by the count.
// Microseconds: remainder * 1e6 (shift-and-add) + total usec, then a
// 20-step restoring division whose quotient is the microsecond part.
module dmms_mean #(
	parameter int SECONDS_WIDTH = dmms_pkg::SECONDS_WIDTH_DEF,
	parameter int COUNT_WIDTH   = dmms_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 take,
	input  logic [COUNT_WIDTH-1:0]               count,
	input  logic [SECONDS_WIDTH+COUNT_WIDTH-1:0] sum_sec,
	input  logic [dmms_pkg::USEC_W-1:0]          sum_usec,
	output logic                                 idle,
	output logic                                 done,
	output logic [SECONDS_WIDTH-1:0]             mean_sec,
	output logic [dmms_pkg::USEC_W-1:0]          mean_usec
);

	localparam int UW   = dmms_pkg::USEC_W;
	localparam int SUMW = SECONDS_WIDTH + COUNT_WIDTH;
	localparam int DVW  = (SUMW > UW) ? SUMW : UW;
	localparam int AW   = COUNT_WIDTH + UW;
	localparam int CNTW = $clog2(DVW);

	dmms_pkg::mean_state_t state_q, state_d;

	logic [COUNT_WIDTH-1:0]   rem_q;
	logic [DVW-1:0]           dvd_q;
	logic [AW-1:0]            acc_q;
	logic [CNTW-1:0]          cnt_q;
	logic [SECONDS_WIDTH-1:0] msec_q;
	logic                     sat_q;

	// Shared adder operands
	logic [AW-1:0]          op_a, op_b;
	logic                   op_sub;
	logic [AW:0]            alu_res;
	logic [COUNT_WIDTH:0]   div_t;
	logic                   div_ge;
	logic [COUNT_WIDTH-1:0] rem_next;
	logic [DVW-1:0]         dvd_next;
	logic                   mul_bit;
	logic                   last;

	assign div_t   = {rem_q, dvd_q[DVW-1]};
	assign mul_bit = dmms_pkg::USEC_PER_SEC[cnt_q[dmms_pkg::USEC_IDX_W-1:0]];
	assign last    = (cnt_q == '0);

	always_comb begin
		op_a   = AW'(div_t);
		op_b   = AW'(count);
		op_sub = 1'b1;
		case (state_q)
			dmms_pkg::MS_MUL: begin
				op_a   = {acc_q[AW-2:0], 1'b0};
				op_b   = mul_bit ? AW'(rem_q) : '0;
				op_sub = 1'b0;
			end
			dmms_pkg::MS_ADDU: begin
				op_a   = acc_q;
				op_b   = AW'(sum_usec);
				op_sub = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign alu_res = {1'b0, op_a} + (op_sub ? ~{1'b0, op_b} : {1'b0, op_b})
		+ (AW + 1)'(op_sub);

	// Restoring division step
	assign div_ge   = !alu_res[AW];
	assign rem_next = div_ge ? alu_res[COUNT_WIDTH-1:0] : div_t[COUNT_WIDTH-1:0];
	assign dvd_next = {dvd_q[DVW-2:0], div_ge};

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmms_pkg::MS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and outputs
	always_comb begin
		state_d = state_q;
		idle    = 1'b0;
		done    = 1'b0;
		case (state_q)
			dmms_pkg::MS_IDLE: begin
				idle = 1'b1;
				if (start) state_d = dmms_pkg::MS_LOAD;
			end
			dmms_pkg::MS_LOAD: state_d = dmms_pkg::MS_DIVS;
			dmms_pkg::MS_DIVS: if (last) state_d = dmms_pkg::MS_MUL;
			dmms_pkg::MS_MUL:  if (last) state_d = dmms_pkg::MS_ADDU;
			dmms_pkg::MS_ADDU: state_d = dmms_pkg::MS_DIVU;
			dmms_pkg::MS_DIVU: if (last) state_d = dmms_pkg::MS_DONE;
			dmms_pkg::MS_DONE: begin
				done = 1'b1;
				if (take) state_d = dmms_pkg::MS_IDLE;
			end
			default: state_d = dmms_pkg::MS_IDLE;
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			dmms_pkg::MS_LOAD: begin
				rem_q <= '0;
				dvd_q <= DVW'(sum_sec);
				cnt_q <= CNTW'(DVW - 1);
			end
			dmms_pkg::MS_DIVS: begin
				rem_q <= rem_next;
				dvd_q <= dvd_next;
				cnt_q <= cnt_q - 1'b1;
				if (last) begin
					msec_q <= dvd_next[SECONDS_WIDTH-1:0];
					sat_q  <= |(dvd_next >> SECONDS_WIDTH);
					acc_q  <= '0;
					cnt_q  <= CNTW'(UW - 1);
				end
			end
			dmms_pkg::MS_MUL: begin
				acc_q <= alu_res[AW-1:0];
				cnt_q <= cnt_q - 1'b1;
			end
			dmms_pkg::MS_ADDU: begin
				rem_q <= alu_res[AW-1:UW];
				dvd_q <= DVW'(alu_res[UW-1:0]) << (DVW - UW);
				cnt_q <= CNTW'(UW - 1);
			end
			dmms_pkg::MS_DIVU: begin
				rem_q <= rem_next;
				dvd_q <= dvd_next;
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign mean_sec  = sat_q ? '1 : msec_q;
	assign mean_usec = sat_q ? dmms_pkg::USEC_MAX : dvd_q[UW-1:0];

endmodule

// File: test/duration_stats_checker.sv
`timescale 1ns / 100ps

// Watches both channels, tracks the running statistics and checks every result.
module duration_stats_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic [dmms_pkg::SECONDS_WIDTH_DEF-1:0] sample_sec,
	input  logic [dmms_pkg::USEC_W-1:0]            sample_usec,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic [dmms_pkg::COUNT_WIDTH_DEF-1:0]   use_count,
	input  logic [dmms_pkg::SECONDS_WIDTH_DEF-1:0] min_sec,
	input  logic [dmms_pkg::USEC_W-1:0]            min_usec,
	input  logic [dmms_pkg::SECONDS_WIDTH_DEF-1:0] max_sec,
	input  logic [dmms_pkg::USEC_W-1:0]            max_usec,
	input  logic [dmms_pkg::SECONDS_WIDTH_DEF-1:0] mean_sec,
	input  logic [dmms_pkg::USEC_W-1:0]            mean_usec,
	output int                                     fail_count,
	output int                                     pending,
	output int                                     checked
);

	localparam int SW = dmms_pkg::SECONDS_WIDTH_DEF;
	localparam int CW = dmms_pkg::COUNT_WIDTH_DEF;
	localparam int UW = dmms_pkg::USEC_W;
	localparam int TW = SW + CW;

	typedef struct packed {
		bit [CW-1:0] use_count;
		bit [SW-1:0] min_sec;
		bit [UW-1:0] min_usec;
		bit [SW-1:0] max_sec;
		bit [UW-1:0] max_usec;
		bit [SW-1:0] mean_sec;
		bit [UW-1:0] mean_usec;
	} duration_stats_t;

	// Running state, mirrors what the block keeps
	bit [CW-1:0] n_samples;
	bit [SW-1:0] lo_sec;
	bit [UW-1:0] lo_usec;
	bit [SW-1:0] hi_sec;
	bit [UW-1:0] hi_usec;
	bit [TW-1:0] tot_sec;
	bit [UW-1:0] tot_usec;

	duration_stats_t expected_stats[$];
	duration_stats_t want;

	// Fold one duration into the statistics and return the updated result
	function automatic duration_stats_t fold_sample(input bit [SW-1:0] s, input bit [UW-1:0] u_in);
		bit [UW-1:0] u;
		bit [UW:0] nu;
		bit [TW-1:0] ns;
		bit [63:0] msec;
		bit [63:0] rem;
		bit [63:0] frac;
		bit [63:0] scale;
		bit [63:0] digit;
		duration_stats_t r;
		// out-of-range microseconds clamp to the top of the range
		u = (u_in > dmms_pkg::USEC_MAX) ? dmms_pkg::USEC_MAX : u_in;
		if (n_samples != {CW{1'b1}})
			n_samples++;
		// a zero min/max reads as unset and is always replaced
		if ((lo_sec == 0 && lo_usec == 0) || s < lo_sec || (s == lo_sec && u < lo_usec)) begin
			lo_sec = s;
			lo_usec = u;
		end
		if ((hi_sec == 0 && hi_usec == 0) || hi_sec < s || (hi_sec == s && hi_usec < u)) begin
			hi_sec = s;
			hi_usec = u;
		end
		// total with a single carry, pinned once it would overflow
		nu = {1'b0, tot_usec} + u;
		ns = TW'(s);
		if (nu >= dmms_pkg::USEC_PER_SEC) begin
			nu = nu - dmms_pkg::USEC_PER_SEC;
			ns++;
		end
		if (tot_sec > ({TW{1'b1}} - ns)) begin
			tot_sec = {TW{1'b1}};
			tot_usec = dmms_pkg::USEC_MAX;
		end else begin
			tot_sec = tot_sec + ns;
			tot_usec = nu[UW-1:0];
		end
		// mean: whole seconds, then six decimal digits of long division
		msec = 64'(tot_sec / n_samples);
		rem = 64'(tot_sec % n_samples);
		frac = 0;
		scale = 100000;
		for (int k = 0; k < 6; k++) begin
			digit = (tot_usec / scale) % 10;
			rem = rem * 10 + digit;
			frac = frac * 10 + rem / n_samples;
			rem = rem % n_samples;
			scale = scale / 10;
		end
		if (msec > {SW{1'b1}}) begin
			msec = {SW{1'b1}};
			frac = 64'(dmms_pkg::USEC_MAX);
		end
		r.use_count = n_samples;
		r.min_sec = lo_sec;
		r.min_usec = lo_usec;
		r.max_sec = hi_sec;
		r.max_usec = hi_usec;
		r.mean_sec = msec[SW-1:0];
		r.mean_usec = frac[UW-1:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_val, input logic [63:0] got);
		if (got !== exp_val) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, got);
			fail_count++;
		end
	endtask

	// Results are retired before the request of the same edge is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_samples = '0;
			lo_sec = '0;
			lo_usec = '0;
			hi_sec = '0;
			hi_usec = '0;
			tot_sec = '0;
			tot_usec = '0;
			expected_stats.delete();
			pending = 0;
			fail_count = 0;
			checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_stats.size() == 0) begin
					$display("%0t: unexpected result, expected none actual use_count %0d",
						$time, use_count);
					fail_count++;
				end else begin
					want = expected_stats.pop_front();
					check_field("use_count", 64'(want.use_count), 64'(use_count));
					check_field("min_sec", 64'(want.min_sec), 64'(min_sec));
					check_field("min_usec", 64'(want.min_usec), 64'(min_usec));
					check_field("max_sec", 64'(want.max_sec), 64'(max_sec));
					check_field("max_usec", 64'(want.max_usec), 64'(max_usec));
					check_field("mean_sec", 64'(want.mean_sec), 64'(mean_sec));
					check_field("mean_usec", 64'(want.mean_usec), 64'(mean_usec));
					checked++;
				end
			end
			if (in_valid && in_ready)
				expected_stats.push_back(fold_sample(sample_sec, sample_usec));
			pending = expected_stats.size();
		end
	end

endmodule

// File: test/duration_min_max_mean_stats_top_test.sv
`timescale 1ns / 100ps

module duration_min_max_mean_stats_top_test;

	localparam int SW = dmms_pkg::SECONDS_WIDTH_DEF;
	localparam int CW = dmms_pkg::COUNT_WIDTH_DEF;
	localparam int UW = dmms_pkg::USEC_W;
	localparam int RANDOM_PER_PHASE = 310;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 100;
	localparam int DIRECTED_N = 16;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [SW-1:0] sample_sec = '0;
	logic [UW-1:0] sample_usec = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [CW-1:0] use_count;
	logic [SW-1:0] min_sec;
	logic [UW-1:0] min_usec;
	logic [SW-1:0] max_sec;
	logic [UW-1:0] max_usec;
	logic [SW-1:0] mean_sec;
	logic [UW-1:0] mean_usec;

	int fail_count;
	int pending;
	int checked;
	int send_idle_pct = 9;
	int recv_idle_pct = 78;
	int cycles = 0;
	int n_sent = 0;
	int n_zero = 0;
	int n_clamped = 0;

	duration_min_max_mean_stats_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_sec(sample_sec),
		.sample_usec(sample_usec),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.use_count(use_count),
		.min_sec(min_sec),
		.min_usec(min_usec),
		.max_sec(max_sec),
		.max_usec(max_usec),
		.mean_sec(mean_sec),
		.mean_usec(mean_usec)
	);

	duration_stats_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_sec(sample_sec),
		.sample_usec(sample_usec),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.use_count(use_count),
		.min_sec(min_sec),
		.min_usec(min_usec),
		.max_sec(max_sec),
		.max_usec(max_usec),
		.mean_sec(mean_sec),
		.mean_usec(mean_usec),
		.fail_count(fail_count),
		.pending(pending),
		.checked(checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("duration_min_max_mean_stats_top verification failed");
			$finish;
		end
	end

	// One request: optional idle gap, then hold until accepted
	task automatic send_sample(input logic [SW-1:0] s, input logic [UW-1:0] u);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_sec <= s;
		sample_usec <= u;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_sent++;
		if (s == 0 && u == 0)
			n_zero++;
		if (u > dmms_pkg::USEC_MAX)
			n_clamped++;
	endtask

	initial begin
		// zero/unset, clamping, carries, field extremes and single-bit patterns
		bit [SW-1:0] dir_sec [DIRECTED_N] = '{
			16'd0, 16'd5, 16'd0, 16'd3, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF,
			16'd1, 16'd0, 16'hFFFF, 16'd12, 16'h8000, 16'h7FFF, 16'd0, 16'd1
		};
		bit [UW-1:0] dir_usec [DIRECTED_N] = '{
			20'd0, 20'd500000, 20'd0, 20'hFFFFF, 20'd999999, 20'd1, 20'd1000000, 20'd0,
			20'd999999, 20'd999999, 20'hFFFFF, 20'hFFFFF, 20'h80000, 20'h7FFFF, 20'd0, 20'd0
		};
		logic [SW-1:0] s;
		logic [UW-1:0] u;
		logic [SW-1:0] last_s;
		logic [UW-1:0] last_u;

		last_s = '0;
		last_u = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_N; i++)
			send_sample(dir_sec[i], dir_usec[i]);

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 78;
				recv_idle_pct = 9;
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				case ($urandom_range(9))
					0: begin
						// short durations keep the minimum moving
						s = SW'($urandom_range(3));
						u = UW'($urandom_range(999999));
					end
					1: begin
						// out-of-range microseconds
						s = SW'($urandom);
						u = UW'($urandom_range(20'hFFFFF, 1000000));
					end
					2: begin
						// zero duration, reads as unset
						s = '0;
						u = '0;
					end
					3: begin
						// tie with the previous request
						s = last_s;
						u = last_u;
					end
					4: begin
						// near-top values force carries
						s = SW'($urandom_range(16'hFFFF, 16'hFFF0));
						u = UW'($urandom_range(999999, 999000));
					end
					default: begin
						s = SW'($urandom);
						u = UW'($urandom);
					end
				endcase
				send_sample(s, u);
				last_s = s;
				last_u = u;
			end
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);

		$display("Run covered %0d duration requests (%0d zero, %0d with clamped microseconds)",
			n_sent, n_zero, n_clamped);
		$display("under three back-pressure mixes; %0d results compared field by field", checked);
		if (fail_count == 0) begin
			$display("duration_min_max_mean_stats_top verification clean");
		end else begin
			$display("duration_min_max_mean_stats_top verification failed");
		end
		$finish;
	end

endmodule
